// ===== hw/rtl/dfnpr_pkg.sv =====
package dfnpr_pkg;

	// Table geometry
	localparam int MAX_GROUPS  = 64;
	localparam int MAX_SLICES  = 4;
	localparam int TBL_DEPTH   = MAX_GROUPS * MAX_SLICES;
	localparam int TBL_AW      = $clog2(TBL_DEPTH);

	// Field widths
	localparam int GROUP_W     = 6;
	localparam int SLICE_W     = 2;
	localparam int ROUTER_W    = 5;
	localparam int PORT_W      = 7;
	localparam int HOST_W      = 5;
	localparam int VC_W        = 3;
	localparam int CFG_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int ENTRY_W     = ROUTER_W + PORT_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOSTS_PER_ROUTER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTERS_PER_GROUP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_GROUP         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ROUTER        = 2'd3;

	localparam logic [VC_W-1:0] VC_MAX = '1;

	typedef enum logic [0:0] {
		OP_TABLE_WRITE = 1'b0,
		OP_ROUTE       = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t               opcode;
		logic [GROUP_W-1:0]    table_group;
		logic [SLICE_W-1:0]    table_slice;
		logic [ROUTER_W-1:0]   entry_router;
		logic [PORT_W-1:0]     entry_port;
		logic [GROUP_W-1:0]    dest_group;
		logic [GROUP_W-1:0]    via_group;
		logic [ROUTER_W-1:0]   dest_router;
		logic [HOST_W-1:0]     dest_host;
		logic [SLICE_W-1:0]    link_slice;
		logic [PORT_W-1:0]     in_port;
		logic [VC_W-1:0]       in_vc;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] out_port;
		logic [VC_W-1:0]   next_vc;
	} rsp_t;

	typedef struct packed {
		logic [ROUTER_W-1:0] router;
		logic [PORT_W-1:0]   port;
	} entry_t;

endpackage

// ===== hw/rtl/dfnpr_ram.sv =====
module dfnpr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write through the single port, or register a read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/dragonfly_next_port_route_top.sv =====
// Dragonfly next-port selection.
//
// Request channel (req_valid / req_stall / req): one beat carries either a
// table write (opcode OP_TABLE_WRITE) or a packet head to route (OP_ROUTE).
// Response channel (rsp_valid / rsp_stall / rsp): exactly one beat per
// request, in order; table writes answer with port 0 and VC 0.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; write only while the block is empty.
//
// From request acceptance to response valid, a beat passes through the registered
// read of the group-to-global-link table, then the port and VC decision into the
// response register. Throughput is one beat per cycle while the receiver does not
// stall; the single table port is used once per beat, for its write or its
// lookup.
// When the receiver stalls, the response register holds and the stage
// behind it fills, then req_stall rises; no beat is lost or repeated.
// Reset clears the valid flags and sets the registers to one host, one router,
// group 0, router 0. The table is not cleared: entries must be written before
// any packet looks them up.
module dragonfly_next_port_route_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dfnpr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dfnpr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  dfnpr_pkg::req_t                req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output dfnpr_pkg::rsp_t                rsp
);

	import dfnpr_pkg::*;

	logic [CFG_W-1:0]    hosts_q;
	logic [CFG_W-1:0]    routers_q;
	logic [GROUP_W-1:0]  own_group_q;
	logic [ROUTER_W-1:0] own_router_q;

	logic                valid_s1;
	req_t                req_s1;
	logic                hit_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                adv_s2;
	logic                accept;
	logic [GROUP_W-1:0]  look_group;
	logic [GROUP_W-1:0]  look_adj;
	logic                look_ok;
	logic                wr_ok;
	logic                tbl_we;
	logic [TBL_AW-1:0]   tbl_addr;
	logic [ENTRY_W-1:0]  tbl_rdata;
	entry_t              entry;
	logic                global_in;
	logic [VC_W-1:0]     vc_nxt;
	logic [PORT_W-1:0]   entry_local;
	logic [PORT_W-1:0]   dest_local;
	logic [PORT_W-1:0]   port_nxt;
	rsp_t                rsp_nxt;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hosts_q      <= CFG_W'(1);
			routers_q    <= CFG_W'(1);
			own_group_q  <= '0;
			own_router_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOSTS_PER_ROUTER:  hosts_q      <= cfg_data;
				REG_ROUTERS_PER_GROUP: routers_q    <= cfg_data;
				REG_OWN_GROUP:         own_group_q  <= cfg_data[GROUP_W-1:0];
				REG_OWN_ROUTER:        own_router_q <= cfg_data[ROUTER_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: advance when the response register is free or being taken
	assign adv_s2    = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !adv_s2;
	assign accept    = req_valid && !req_stall;

	// Pick the group whose global link is wanted, skip own group in the index
	always_comb begin
		look_group = (req.via_group != own_group_q) ? req.via_group : req.dest_group;
		look_adj   = look_group;
		if (look_group >= own_group_q && look_group != '0) begin
			look_adj = look_group - GROUP_W'(1);
		end
		look_ok = (int'(look_adj) < MAX_GROUPS - 1) && (int'(req.link_slice) < MAX_SLICES);
		wr_ok   = (int'(req.table_group) < MAX_GROUPS - 1)
			&& (int'(req.table_slice) < MAX_SLICES);
	end

	// Drive the table port: write beats write, route beats read
	always_comb begin
		tbl_we = (req.opcode == OP_TABLE_WRITE);
		if (tbl_we) begin
			tbl_addr = TBL_AW'(int'(req.table_group) * MAX_SLICES + int'(req.table_slice));
		end else begin
			tbl_addr = TBL_AW'(int'(look_adj) * MAX_SLICES + int'(req.link_slice));
		end
	end

	dfnpr_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_link_table (
		.clk   (clk),
		.en    (accept && (!tbl_we || wr_ok)),
		.we    (tbl_we),
		.addr  (tbl_addr),
		.wdata ({req.entry_router, req.entry_port}),
		.rdata (tbl_rdata)
	);

	// Stage 1: hold the beat while the table read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			hit_s1 <= look_ok;
		end
	end

	// Decide VC: step up after a global hop, saturating
	always_comb begin
		global_in = ({1'b0, req_s1.in_port} + 8'd1)
			>= ({2'b00, hosts_q} + {2'b00, routers_q});
		vc_nxt = req_s1.in_vc;
		if (global_in && req_s1.in_vc != VC_MAX) begin
			vc_nxt = req_s1.in_vc + VC_W'(1);
		end
	end

	// Decide port: global link, local router port or host port
	always_comb begin
		entry = hit_s1 ? entry_t'(tbl_rdata) : '0;
		entry_local = PORT_W'(hosts_q) + PORT_W'(entry.router)
			- PORT_W'(entry.router > own_router_q);
		dest_local = PORT_W'(hosts_q) + PORT_W'(req_s1.dest_router)
			- PORT_W'(req_s1.dest_router > own_router_q);
		if (req_s1.dest_group != own_group_q) begin
			port_nxt = (entry.router == own_router_q) ? entry.port : entry_local;
		end else if (req_s1.dest_router != own_router_q) begin
			port_nxt = dest_local;
		end else begin
			port_nxt = PORT_W'(req_s1.dest_host);
		end
		if (req_s1.opcode == OP_TABLE_WRITE) begin
			rsp_nxt = '0;
		end else begin
			rsp_nxt.out_port = port_nxt;
			rsp_nxt.next_vc  = vc_nxt;
		end
	end

	// Stage 2: response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s2) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
